// ===== sv/dmcs_pkg.sv =====
// shared constants and controller/datapath interface types for the cache
`timescale 1ns / 1ps
`default_nettype none
package dmcs_pkg;

    localparam int SETS      = 256;
    localparam int ADDR_BITS = 16;

    localparam int ADDR_PORT_W = 16;
    localparam int WORD_W      = 32;
    localparam int OP_W        = 2;

    // address bits that actually reach the cache (port is 16 bits wide)
    localparam int ADDR_W   = (ADDR_BITS < ADDR_PORT_W) ? ADDR_BITS : ADDR_PORT_W;
    localparam int IDX_BITS = $clog2(SETS);
    localparam int TAG_BITS = ADDR_W - IDX_BITS;
    localparam int ENTRY_W  = TAG_BITS + WORD_W;

    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

    localparam logic [WORD_W-1:0] CNT_MAX = {WORD_W{1'b1}};

    typedef struct packed {
        logic load_in;  // capture the request and start the array read
        logic commit;   // update state and load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free; // result register empty or being drained
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== sv/dmcs_ctrl.sv =====
// controller state machine: request accept and commit sequencing
`timescale 1ns / 1ps
`default_nettype none
module dmcs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  dmcs_pkg::t_dp_stat     i_stat,
    output dmcs_pkg::t_dp_cmd      o_cmd
);
    import dmcs_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                // array data is registered now; hold until the result slot frees
                o_cmd.commit = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== sv/dmcs_datapath.sv =====
// datapath: tag/data array, valid bits, hit and miss counters, result register
`timescale 1ns / 1ps
`default_nettype none
module dmcs_datapath (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  dmcs_pkg::t_dp_cmd                             i_cmd,
    output dmcs_pkg::t_dp_stat                            o_stat,
    input  wire logic        [dmcs_pkg::OP_W-1:0]         i_operation,
    input  wire logic        [dmcs_pkg::ADDR_PORT_W-1:0]  i_address,
    input  wire logic signed [dmcs_pkg::WORD_W-1:0]       i_write_data,
    input  wire logic signed [dmcs_pkg::WORD_W-1:0]       i_fill_data,
    output logic                                          o_out_valid,
    input  wire logic                                     i_out_ready,
    output logic signed      [dmcs_pkg::WORD_W-1:0]       o_read_data,
    output logic                                          o_was_hit,
    output logic             [dmcs_pkg::WORD_W-1:0]       o_hits_seen,
    output logic             [dmcs_pkg::WORD_W-1:0]       o_misses_seen
);
    import dmcs_pkg::*;

    // request registers
    logic [OP_W-1:0]   r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [WORD_W-1:0] r_wdata;
    logic [WORD_W-1:0] r_fdata;

    // tag and word array, registered read
    logic [ENTRY_W-1:0] r_mem [SETS];
    logic [ENTRY_W-1:0] r_rd_entry;
    logic [SETS-1:0]    r_line_valid;

    logic [WORD_W-1:0] r_hit_total;
    logic [WORD_W-1:0] r_miss_total;

    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_rdata;
    logic              r_out_hit;
    logic [WORD_W-1:0] r_out_hits;
    logic [WORD_W-1:0] r_out_misses;

    logic [ADDR_W-1:0]   in_addr;
    logic [IDX_BITS-1:0] idx;
    logic [TAG_BITS-1:0] tag;
    logic                hit;
    logic                do_fill;
    logic [WORD_W-1:0]   fill_word;

    assign in_addr = i_address[ADDR_W-1:0];
    assign idx     = r_addr[IDX_BITS-1:0];
    assign tag     = r_addr[ADDR_W-1:IDX_BITS];

    assign hit = (r_op == OP_READ) && r_line_valid[idx]
                 && (r_rd_entry[ENTRY_W-1:WORD_W] == tag);
    // read miss fills from backing word, write allocates
    assign do_fill   = ((r_op == OP_READ) && !hit) || (r_op == OP_WRITE);
    assign fill_word = (r_op == OP_WRITE) ? r_wdata : r_fdata;

    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op       <= i_operation;
            r_addr     <= in_addr;
            r_wdata    <= i_write_data;
            r_fdata    <= i_fill_data;
            r_rd_entry <= r_mem[in_addr[IDX_BITS-1:0]];
        end
        if (i_cmd.commit && do_fill) begin
            r_mem[idx] <= {tag, fill_word};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_hits   <= r_hit_total;
            r_out_misses <= r_miss_total;
            r_out_hit    <= hit;
            if (r_op == OP_READ) begin
                r_out_rdata <= hit ? r_rd_entry[WORD_W-1:0] : r_fdata;
            end else begin
                r_out_rdata <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_valid <= '0;
            r_hit_total  <= '0;
            r_miss_total <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.commit) begin
                if (do_fill) begin
                    r_line_valid[idx] <= 1'b1;
                end
                case (r_op)
                    OP_READ: begin
                        if (hit && (r_hit_total != CNT_MAX)) begin
                            r_hit_total <= r_hit_total + 1'b1;
                        end
                        if (!hit && (r_miss_total != CNT_MAX)) begin
                            r_miss_total <= r_miss_total + 1'b1;
                        end
                    end
                    OP_REPORT: begin
                        r_hit_total  <= '0;
                        r_miss_total <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = signed'(r_out_rdata);
    assign o_was_hit     = r_out_hit;
    assign o_hits_seen   = r_out_hits;
    assign o_misses_seen = r_out_misses;

endmodule
`default_nettype wire

// ===== sv/direct_mapped_cache_with_stats.sv =====
// direct-mapped one-word-per-line cache with saturating hit/miss statistics
// the request and array read are registered on accept; commit then loads the result register once it is free
// one request at a time: a new one is accepted only after the current one commits (array read, then commit)
// the next request is accepted while a finished result waits in the output register
// reset: synchronous; clears valid bits, counters, fsm and result valid
// tag/word array is not cleared; an entry only counts as a hit under a set valid bit
`timescale 1ns / 1ps
`default_nettype none
module direct_mapped_cache_with_stats (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_in_valid,
    output logic                                          o_in_ready,
    input  wire logic        [dmcs_pkg::OP_W-1:0]         i_operation,
    input  wire logic        [dmcs_pkg::ADDR_PORT_W-1:0]  i_address,
    input  wire logic signed [dmcs_pkg::WORD_W-1:0]       i_write_data,
    input  wire logic signed [dmcs_pkg::WORD_W-1:0]       i_fill_data,
    output logic                                          o_out_valid,
    input  wire logic                                     i_out_ready,
    output logic signed      [dmcs_pkg::WORD_W-1:0]       o_read_data,
    output logic                                          o_was_hit,
    output logic             [dmcs_pkg::WORD_W-1:0]       o_hits_seen,
    output logic             [dmcs_pkg::WORD_W-1:0]       o_misses_seen
);
    import dmcs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    dmcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dmcs_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_operation   (i_operation),
        .i_address     (i_address),
        .i_write_data  (i_write_data),
        .i_fill_data   (i_fill_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_data   (o_read_data),
        .o_was_hit     (o_was_hit),
        .o_hits_seen   (o_hits_seen),
        .o_misses_seen (o_misses_seen)
    );

endmodule
`default_nettype wire
